FILE: rtl/ehpc_pkg.sv
// shared types and constants of the ethernet header parser and classifier
package ehpc_pkg;

   localparam int LENGTH_BITS_DEF = 14;
   localparam int LEN_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] ETYPE_ARP = 16'h0806;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0] IPPROTO_TCP = 8'd6;
   localparam logic [7:0] IPPROTO_UDP = 8'd17;
   localparam logic [7:0] IPPROTO_ICMP = 8'd1;

   localparam logic [2:0] PROTO_UNKNOWN = 3'd0;
   localparam logic [2:0] PROTO_ARP = 3'd1;
   localparam logic [2:0] PROTO_TCP = 3'd2;
   localparam logic [2:0] PROTO_UDP = 3'd3;
   localparam logic [2:0] PROTO_ICMP = 3'd4;

   localparam logic [2:0] THREAT_NONE = 3'd0;
   localparam logic [2:0] THREAT_LENGTH = 3'd1;
   localparam logic [2:0] THREAT_NULL = 3'd2;
   localparam logic [2:0] THREAT_XMAS = 3'd3;
   localparam logic [2:0] THREAT_SYNFIN = 3'd4;

   localparam logic [7:0] FLAG_FIN = 8'h01;
   localparam logic [7:0] FLAG_SYN = 8'h02;
   localparam logic [7:0] FLAG_XMAS = 8'h29;

   // header fields picked off the byte stream, one record per frame
   typedef struct packed {
      logic [LEN_W-1:0] frame_len;
      logic [15:0] ethertype;
      logic [3:0] ihl;
      logic [15:0] ip_total;
      logic [7:0] ip_proto;
      logic [31:0] ip_src;
      logic [31:0] ip_dst;
      logic [15:0] arp_op;
      logic [47:0] arp_mac;
      logic [31:0] arp_sip;
      logic [31:0] arp_tip;
      logic [63:0] l4_head;
      logic [7:0] tcp_flags;
   } hdr_rec_type;

   typedef struct packed {
      logic status;
      logic [2:0] protocol;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0] tcp_flag_bits;
      logic [31:0] aux_value;
      logic [15:0] icmp_type_code;
      logic [47:0] arp_sha;
      logic [2:0] threat_class;
      logic [13:0] frame_length;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

FILE: rtl/ehpc_front.sv
// front end: counts frame bytes and captures header fields as they pass
module ehpc_front
   import ehpc_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [7:0] byte_value,
   input  logic last_byte,
   output logic rec_push,
   output hdr_rec_type rec
);

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

   logic [LENGTH_BITS-1:0] count_ff, count_in;
   hdr_rec_type rec_ff, rec_in;

   always_comb begin
      logic [LEN_W-1:0] pos;
      logic [LEN_W-1:0] l4;
      logic [LEN_W-1:0] rel;
      pos = LEN_W'(count_ff);
      l4 = LEN_W'(14) + LEN_W'({rec_ff.ihl, 2'b00});
      rel = pos - l4;
      rec_in = rec_ff;
      for (int k = 0; k < 2; k++) begin
         if (pos == LEN_W'(12 + k)) rec_in.ethertype[15-8*k -: 8] = byte_value;
         if (pos == LEN_W'(16 + k)) rec_in.ip_total[15-8*k -: 8] = byte_value;
         if (pos == LEN_W'(20 + k)) rec_in.arp_op[15-8*k -: 8] = byte_value;
      end
      if (pos == LEN_W'(14)) rec_in.ihl = byte_value[3:0];
      if (pos == LEN_W'(23)) rec_in.ip_proto = byte_value;
      for (int k = 0; k < 4; k++) begin
         if (pos == LEN_W'(26 + k)) rec_in.ip_src[31-8*k -: 8] = byte_value;
         if (pos == LEN_W'(30 + k)) rec_in.ip_dst[31-8*k -: 8] = byte_value;
         if (pos == LEN_W'(28 + k)) rec_in.arp_sip[31-8*k -: 8] = byte_value;
         if (pos == LEN_W'(38 + k)) rec_in.arp_tip[31-8*k -: 8] = byte_value;
      end
      for (int k = 0; k < 6; k++) begin
         if (pos == LEN_W'(22 + k)) rec_in.arp_mac[47-8*k -: 8] = byte_value;
      end
      // transport header bytes sit at an offset set by the ip header length
      for (int k = 0; k < 8; k++) begin
         if (rel == LEN_W'(k)) rec_in.l4_head[63-8*k -: 8] = byte_value;
      end
      if (rel == LEN_W'(13)) rec_in.tcp_flags = byte_value;
      if (count_ff == COUNT_MAX) begin
         rec_in.frame_len = LEN_W'(count_ff);
      end else begin
         rec_in.frame_len = LEN_W'(count_ff) + LEN_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (last_byte) begin
            count_in = '0;
         end else if (count_ff != COUNT_MAX) begin
            count_in = count_ff + LENGTH_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (accept) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_push = accept & last_byte;
   assign rec = rec_in;

endmodule

FILE: rtl/ehpc_queue.sv
// short queue of header records between the front and back ends
module ehpc_queue
   import ehpc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  hdr_rec_type push_rec,
   input  logic pop,
   output hdr_rec_type head_rec,
   output qstat_type stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   hdr_rec_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic do_push, do_pop;

   assign stat.full = (level_ff == LVL_W'(QUEUE_DEPTH));
   assign stat.empty = (level_ff == '0);
   assign do_push = push & ~stat.full;
   assign do_pop = pop & ~stat.empty;
   assign head_rec = entry_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      level_in = level_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (!do_push && do_pop) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         level_ff <= level_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= push_rec;
      end
   end

endmodule

FILE: rtl/ehpc_back.sv
// back end: classifies a header record and holds the result for the consumer
module ehpc_back
   import ehpc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  hdr_rec_type rec,
   input  qstat_type qstat,
   output logic rec_pop,
   input  logic pop,
   output logic empty,
   output rsp_type rsp
);

   rsp_type res, rsp_ff;
   logic valid_ff, valid_in;

   always_comb begin
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] ihl4;
      logic [LEN_W-1:0] l4;
      len = rec.frame_len;
      ihl4 = LEN_W'({rec.ihl, 2'b00});
      l4 = LEN_W'(14) + ihl4;
      res = '0;
      if (len < LEN_W'(14)) begin
         res.status = 1'b1;
      end else if (rec.ethertype == ETYPE_ARP) begin
         if (len < LEN_W'(42)) begin
            res.status = 1'b1;
         end else begin
            res.protocol = PROTO_ARP;
            res.aux_value = {16'h0, rec.arp_op};
            res.arp_sha = rec.arp_mac;
            res.source_ip = rec.arp_sip;
            res.dest_ip = rec.arp_tip;
         end
      end else if (rec.ethertype == ETYPE_IPV4) begin
         if (len < LEN_W'(34) || ihl4 < LEN_W'(20) || l4 > len) begin
            res.status = 1'b1;
         end else begin
            res.source_ip = rec.ip_src;
            res.dest_ip = rec.ip_dst;
            if (LEN_W'(rec.ip_total) > len - LEN_W'(14)) res.threat_class = THREAT_LENGTH;
            if (rec.ip_proto == IPPROTO_TCP) begin
               if (len < l4 + LEN_W'(20)) begin
                  res = '0;
                  res.status = 1'b1;
               end else begin
                  res.protocol = PROTO_TCP;
                  res.source_port = rec.l4_head[63:48];
                  res.dest_port = rec.l4_head[47:32];
                  res.aux_value = rec.l4_head[31:0];
                  res.tcp_flag_bits = rec.tcp_flags;
                  if (rec.tcp_flags == FLAG_SYN) begin
                     res.threat_class = res.threat_class;
                  end else if (rec.tcp_flags == 8'h00) begin
                     res.threat_class = THREAT_NULL;
                  end else if (rec.tcp_flags == FLAG_XMAS) begin
                     res.threat_class = THREAT_XMAS;
                  end else if ((rec.tcp_flags & FLAG_SYN) != 8'h00 &&
                               (rec.tcp_flags & FLAG_FIN) != 8'h00) begin
                     res.threat_class = THREAT_SYNFIN;
                  end
               end
            end else if (rec.ip_proto == IPPROTO_UDP) begin
               if (len < l4 + LEN_W'(8)) begin
                  res = '0;
                  res.status = 1'b1;
               end else begin
                  res.protocol = PROTO_UDP;
                  res.source_port = rec.l4_head[63:48];
                  res.dest_port = rec.l4_head[47:32];
                  res.aux_value = {16'h0, rec.l4_head[31:16]};
               end
            end else if (rec.ip_proto == IPPROTO_ICMP) begin
               if (len < l4 + LEN_W'(8)) begin
                  res = '0;
                  res.status = 1'b1;
               end else begin
                  res.protocol = PROTO_ICMP;
                  res.aux_value = {16'h0, rec.l4_head[15:0]};
                  res.icmp_type_code = rec.l4_head[63:48];
               end
            end
         end
      end
      res.frame_length = len[13:0];
   end

   // refill the output register whenever it is free or being taken
   assign rec_pop = ~qstat.empty & (~valid_ff | pop);
   assign valid_in = rec_pop | (valid_ff & ~pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (rec_pop) begin
         rsp_ff <= res;
      end
   end

   assign empty = ~valid_ff;
   assign rsp = rsp_ff;

endmodule

FILE: rtl/ethernet_header_parser_classifier.sv
// top level of the ethernet / ipv4 / l4 header parser and classifier
// Takes one frame byte per clock with a last-byte mark and delivers one result
// transaction per frame: status, protocol, addresses, ports, flags, aux value and
// threat class. Bytes are taken every cycle as long as the two-entry record queue
// has room; header fields are captured as the bytes pass, so no frame is stored.
// A result passes the record queue and the output register after the frame's last
// byte, and the result side drains one transaction per clock while records wait.
// The frame length count saturates at 2**LENGTH_BITS - 1, reported in low 14 bits.
module ethernet_header_parser_classifier
   import ehpc_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [7:0] req_byte_value,
   input  logic req_last_byte,
   output logic empty,
   input  logic pop,
   output logic rsp_status,
   output logic [2:0] rsp_protocol,
   output logic [31:0] rsp_source_ip,
   output logic [31:0] rsp_dest_ip,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dest_port,
   output logic [7:0] rsp_tcp_flag_bits,
   output logic [31:0] rsp_aux_value,
   output logic [15:0] rsp_icmp_type_code,
   output logic [47:0] rsp_arp_sha,
   output logic [2:0] rsp_threat_class,
   output logic [13:0] rsp_frame_length
);

   logic accept, rec_push, rec_pop;
   hdr_rec_type front_rec, head_rec;
   qstat_type qstat;
   rsp_type rsp;

   assign full = qstat.full;
   assign accept = push & ~qstat.full;

   ehpc_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .byte_value(req_byte_value), .last_byte(req_last_byte),
      .rec_push(rec_push), .rec(front_rec)
   );

   ehpc_queue u_queue (
      .clock(clock), .reset(reset), .push(rec_push), .push_rec(front_rec),
      .pop(rec_pop), .head_rec(head_rec), .stat(qstat)
   );

   ehpc_back u_back (
      .clock(clock), .reset(reset), .rec(head_rec), .qstat(qstat),
      .rec_pop(rec_pop), .pop(pop), .empty(empty), .rsp(rsp)
   );

   assign rsp_status = rsp.status;
   assign rsp_protocol = rsp.protocol;
   assign rsp_source_ip = rsp.source_ip;
   assign rsp_dest_ip = rsp.dest_ip;
   assign rsp_source_port = rsp.source_port;
   assign rsp_dest_port = rsp.dest_port;
   assign rsp_tcp_flag_bits = rsp.tcp_flag_bits;
   assign rsp_aux_value = rsp.aux_value;
   assign rsp_icmp_type_code = rsp.icmp_type_code;
   assign rsp_arp_sha = rsp.arp_sha;
   assign rsp_threat_class = rsp.threat_class;
   assign rsp_frame_length = rsp.frame_length;

`ifndef SYNTH
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status |-> rsp_protocol == PROTO_UNKNOWN &&
      rsp_threat_class == THREAT_NONE && rsp_aux_value == 32'h0)
      else $error("error result carries parsed fields");
   a_scan_tcp: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_threat_class != THREAT_NONE &&
      rsp_threat_class != THREAT_LENGTH |-> rsp_protocol == PROTO_TCP)
      else $error("tcp scan class on a non-tcp result");
   a_queue_stat: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("record queue both full and empty");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rec_pop |=> !empty)
      else $error("result lost after leaving the queue");
`endif

endmodule

FILE: verif/frame_result_checker.sv
// checker: watches the byte and result channels, predicts frame results and compares
`timescale 1ns / 1ps
module frame_result_checker
   import ehpc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic full,
   input  logic [7:0] req_byte_value,
   input  logic req_last_byte,
   input  logic empty,
   input  logic pop,
   input  rsp_type rsp_seen,
   output int error_count,
   output int pending_count
);

   localparam int STORE_BYTES = 128;
   localparam int COUNT_MAX = (1 << 14) - 1;

   logic [7:0] hdr_bytes [STORE_BYTES];
   int byte_total;
   rsp_type frame_results [$];

   function automatic logic [7:0] hb(input int i);
      if (i < STORE_BYTES) return hdr_bytes[i];
      return 8'h00;
   endfunction

   function automatic logic [15:0] hw(input int i);
      return {hb(i), hb(i + 1)};
   endfunction

   function automatic logic [31:0] hl(input int i);
      return {hw(i), hw(i + 2)};
   endfunction

   function automatic rsp_type classify_frame(input int len);
      rsp_type r;
      logic [15:0] etype;
      int ihl, l4;
      logic [7:0] proto, fl;
      r = '0;
      r.frame_length = len[13:0];
      if (len < 14) begin
         r.status = 1'b1;
         return r;
      end
      etype = hw(12);
      if (etype == ETYPE_ARP) begin
         if (len < 42) begin
            r.status = 1'b1;
            return r;
         end
         r.protocol = PROTO_ARP;
         r.aux_value = {16'h0, hw(20)};
         r.arp_sha = {hw(22), hl(24)};
         r.source_ip = hl(28);
         r.dest_ip = hl(38);
         return r;
      end
      if (etype != ETYPE_IPV4) return r;
      if (len < 34) begin
         r.status = 1'b1;
         return r;
      end
      ihl = hb(14) % 16 * 4;
      if (ihl < 20 || 14 + ihl > len) begin
         r.status = 1'b1;
         return r;
      end
      r.source_ip = hl(26);
      r.dest_ip = hl(30);
      if (int'(hw(16)) > len - 14) r.threat_class = THREAT_LENGTH;
      l4 = 14 + ihl;
      proto = hb(23);
      if (proto == IPPROTO_TCP) begin
         if (len < l4 + 20) begin
            r = '0;
            r.status = 1'b1;
            r.frame_length = len[13:0];
            return r;
         end
         r.protocol = PROTO_TCP;
         r.source_port = hw(l4);
         r.dest_port = hw(l4 + 2);
         r.aux_value = hl(l4 + 4);
         fl = hb(l4 + 13);
         r.tcp_flag_bits = fl;
         if (fl == FLAG_SYN) begin
         end else if (fl == 8'h00) begin
            r.threat_class = THREAT_NULL;
         end else if (fl == FLAG_XMAS) begin
            r.threat_class = THREAT_XMAS;
         end else if ((fl & FLAG_SYN) != 0 && (fl & FLAG_FIN) != 0) begin
            r.threat_class = THREAT_SYNFIN;
         end
      end else if (proto == IPPROTO_UDP) begin
         if (len < l4 + 8) begin
            r = '0;
            r.status = 1'b1;
            r.frame_length = len[13:0];
            return r;
         end
         r.protocol = PROTO_UDP;
         r.source_port = hw(l4);
         r.dest_port = hw(l4 + 2);
         r.aux_value = {16'h0, hw(l4 + 4)};
      end else if (proto == IPPROTO_ICMP) begin
         if (len < l4 + 8) begin
            r = '0;
            r.status = 1'b1;
            r.frame_length = len[13:0];
            return r;
         end
         r.protocol = PROTO_ICMP;
         r.aux_value = {16'h0, hw(l4 + 6)};
         r.icmp_type_code = hw(l4);
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_v,
         input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         error_count++;
      end
   endtask

   assign pending_count = frame_results.size();

   always @(posedge clock) begin
      rsp_type e;
      int len;
      if (reset) begin
         byte_total = 0;
         error_count = 0;
         frame_results.delete();
      end else begin
         if (push && !full) begin
            if (byte_total < STORE_BYTES) hdr_bytes[byte_total] = req_byte_value;
            if (byte_total < COUNT_MAX) byte_total++;
            if (req_last_byte) begin
               len = byte_total;
               byte_total = 0;
               frame_results.push_back(classify_frame(len));
            end
         end
         if (pop && !empty) begin
            if (frame_results.size() == 0) begin
               $error("result transaction with nothing expected");
               error_count++;
            end else begin
               e = frame_results.pop_front();
               check_field("status", e.status, rsp_seen.status);
               check_field("protocol", e.protocol, rsp_seen.protocol);
               check_field("source_ip", e.source_ip, rsp_seen.source_ip);
               check_field("dest_ip", e.dest_ip, rsp_seen.dest_ip);
               check_field("source_port", e.source_port, rsp_seen.source_port);
               check_field("dest_port", e.dest_port, rsp_seen.dest_port);
               check_field("tcp_flag_bits", e.tcp_flag_bits, rsp_seen.tcp_flag_bits);
               check_field("aux_value", e.aux_value, rsp_seen.aux_value);
               check_field("icmp_type_code", e.icmp_type_code, rsp_seen.icmp_type_code);
               check_field("arp_sha", e.arp_sha, rsp_seen.arp_sha);
               check_field("threat_class", e.threat_class, rsp_seen.threat_class);
               check_field("frame_length", e.frame_length, rsp_seen.frame_length);
            end
         end
      end
   end

endmodule

FILE: verif/tb_top.sv
// testbench top: builds byte streams of frames and gives the verdict
`timescale 1ns / 1ps
module tb_top
   import ehpc_pkg::*;
;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [7:0] req_byte_value = 8'h00;
   logic req_last_byte = 1'b0;
   logic empty;
   logic pop = 1'b0;
   rsp_type rsp_seen;
   int error_count, pending_count;
   int bytes_sent;
   logic [7:0] frame_buf [$];

   always #2 clock = ~clock;

   ethernet_header_parser_classifier dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_byte_value(req_byte_value), .req_last_byte(req_last_byte),
      .empty(empty), .pop(pop),
      .rsp_status(rsp_seen.status), .rsp_protocol(rsp_seen.protocol),
      .rsp_source_ip(rsp_seen.source_ip), .rsp_dest_ip(rsp_seen.dest_ip),
      .rsp_source_port(rsp_seen.source_port), .rsp_dest_port(rsp_seen.dest_port),
      .rsp_tcp_flag_bits(rsp_seen.tcp_flag_bits), .rsp_aux_value(rsp_seen.aux_value),
      .rsp_icmp_type_code(rsp_seen.icmp_type_code),
      .rsp_arp_sha(rsp_seen.arp_sha), .rsp_threat_class(rsp_seen.threat_class),
      .rsp_frame_length(rsp_seen.frame_length)
   );

   frame_result_checker checker_i (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_byte_value(req_byte_value), .req_last_byte(req_last_byte),
      .empty(empty), .pop(pop), .rsp_seen(rsp_seen),
      .error_count(error_count), .pending_count(pending_count)
   );

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // random stalls on the result side, with calm stretches
   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else if (bytes_sent / 400 % 3 == 1) pop <= 1'b1;
      else if ($urandom_range(0, 24) == 0) pop <= 1'b0;
      else pop <= $urandom_range(0, 3) != 0;
   end

   task automatic send_frame(input bit gaps);
      int g;
      for (int i = 0; i < frame_buf.size(); i++) begin
         g = gaps ? gap_len() : 0;
         if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge clock);
         end
         push <= 1'b1;
         req_byte_value <= frame_buf[i];
         req_last_byte <= (i == frame_buf.size() - 1);
         @(posedge clock);
         while (full) @(posedge clock);
         bytes_sent++;
      end
      push <= 1'b0;
      req_last_byte <= 1'b0;
   endtask

   task automatic put16(input int at, input logic [15:0] v);
      frame_buf[at] = v[15:8];
      frame_buf[at + 1] = v[7:0];
   endtask

   // kind: 0 arp, 1 tcp, 2 udp, 3 icmp, 4 other ip proto, 5 other ethertype
   task automatic build_frame(input int kind, input int ihl_nib, input int len,
         input logic [7:0] flags);
      frame_buf.delete();
      for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
      if (len >= 14) begin
         case (kind)
            0: put16(12, ETYPE_ARP);
            5: put16(12, 16'($urandom_range(0, 1) ? $urandom : 16'h0801));
            default: put16(12, ETYPE_IPV4);
         endcase
      end
      if (kind >= 1 && kind <= 4 && len >= 34) begin
         frame_buf[14] = {4'h4, 4'(ihl_nib)};
         if ($urandom_range(0, 1)) put16(16, 16'($urandom_range(0, len + 5) - 14));
         case (kind)
            1: frame_buf[23] = IPPROTO_TCP;
            2: frame_buf[23] = IPPROTO_UDP;
            3: frame_buf[23] = IPPROTO_ICMP;
            default: frame_buf[23] = 8'($urandom_range(0, 1) ? 255 : 2);
         endcase
         if (kind == 1 && 14 + ihl_nib * 4 + 13 < len) frame_buf[14 + ihl_nib * 4 + 13] = flags;
      end
   endtask

   function automatic logic [7:0] pick_flags();
      case ($urandom_range(0, 5))
         0: return FLAG_SYN;
         1: return 8'h00;
         2: return FLAG_XMAS;
         3: return 8'h03 | 8'($urandom);
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      int kind, ihl_nib, len;
      bytes_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed frames: short, each protocol, threat patterns, truncations
      build_frame(5, 5, 1, 0); send_frame(0);
      build_frame(5, 5, 13, 0); send_frame(0);
      build_frame(0, 5, 41, 0); send_frame(1);
      build_frame(0, 5, 42, 0); send_frame(0);
      build_frame(1, 5, 33, 0); send_frame(0);
      build_frame(1, 4, 60, 0); send_frame(0);
      build_frame(1, 15, 60, 0); send_frame(0);
      build_frame(1, 15, 74, FLAG_SYN); send_frame(1);
      build_frame(1, 5, 54, FLAG_SYN); send_frame(0);
      build_frame(1, 5, 54, 8'h00); send_frame(0);
      build_frame(1, 5, 54, FLAG_XMAS); send_frame(0);
      build_frame(1, 5, 54, 8'hFF); send_frame(0);
      build_frame(1, 5, 53, 8'h00); send_frame(0);
      build_frame(2, 5, 42, 0); send_frame(0);
      build_frame(2, 5, 41, 0); send_frame(0);
      build_frame(3, 5, 42, 0); send_frame(0);
      build_frame(3, 6, 45, 0); send_frame(0);
      build_frame(4, 5, 34, 0); send_frame(0);
      build_frame(5, 5, 64, 0); send_frame(0);
      // frame bytes beyond the store
      build_frame(2, 5, 200, 0); send_frame(0);
      while (bytes_sent < 1650) begin
         len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 140) : $urandom_range(34, 80);
         kind = $urandom_range(0, 5);
         ihl_nib = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(5, 7);
         build_frame(kind, ihl_nib, len, pick_flags());
         send_frame(1);
      end
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ehpc_pkg.sv
rtl/ehpc_front.sv
rtl/ehpc_queue.sv
rtl/ehpc_back.sv
rtl/ethernet_header_parser_classifier.sv
verif/frame_result_checker.sv
verif/tb_top.sv
